### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/owff_pkg.sv
// ---------------------------------------------------------------------------
// owff_pkg
// shared types and constants of the overwrite-oldest frame fifo
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package owff_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  // field widths
  localparam int ID_W    = 29;
  localparam int LEN_W   = 4;
  localparam int PAY_W   = 64;
  localparam int TS_W    = 32;
  localparam int CNT_W   = 32;
  localparam int FILL_W  = 10;
  localparam int KIND_W  = 2;

  // frame word: identifier, extended, remote, length, payload, timestamp
  localparam int FRAME_W = ID_W + 1 + 1 + LEN_W + PAY_W + TS_W;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((FRAME_W + 7) / 8) * 8;
  localparam int OUT_STAT_W  = FILL_W + CNT_W + CNT_W + FILL_W + 1;
  localparam int OUT_TDATA_W = ((FRAME_W + OUT_STAT_W + 7) / 8) * 8;

  // bit positions of the status fields in the result tdata
  localparam int FILL_LSB  = FRAME_W;
  localparam int DROP_LSB  = FILL_LSB + FILL_W;
  localparam int FRAMES_LSB = DROP_LSB + CNT_W;
  localparam int PEAK_LSB  = FRAMES_LSB + CNT_W;
  localparam int OVER_BIT  = PEAK_LSB + FILL_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_STATS = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    ST_IDLE     = 1'b0,
    ST_POP_WAIT = 1'b1
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic  accept;   // request taken this cycle
    kind_e kind;     // kind of the request taken
    logic  load;     // load the result register
    logic  use_ram;  // result carries the frame read from memory
  } cmd_t;

endpackage

### rtl/core/owff_ram.sv
// ---------------------------------------------------------------------------
// owff_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module owff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/owff_ctrl.sv
// ---------------------------------------------------------------------------
// owff_ctrl
// request handshake and sequencing of pops through the memory read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module owff_ctrl import owff_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] in_kind_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              ring_empty_i,
  output cmd_t              cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // result register can take a new result this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // state and result flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.accept  = 1'b0;
    cmd_o.kind    = kind_e'(in_kind_i);
    cmd_o.load    = 1'b0;
    cmd_o.use_ram = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = out_free;
        cmd_o.accept = in_valid_i && out_free;
        if (cmd_o.accept) begin
          if (cmd_o.kind == KIND_POP && !ring_empty_i) begin
            state_d = ST_POP_WAIT;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_POP_WAIT: begin
        if (out_free) begin
          cmd_o.load    = 1'b1;
          cmd_o.use_ram = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/core/owff_datapath.sv
// ---------------------------------------------------------------------------
// owff_datapath
// ring pointers, statistics counters, frame memory and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module owff_datapath import owff_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  input  logic [IN_TDATA_W-1:0]  in_data_i,
  output logic                   ring_empty_o,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_user_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] DEPTH_P   = PTR_W'(DEPTH);

  logic [PTR_W-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W-1:0]       wr_next, rd_next;
  logic [PTR_W-1:0]       level_now, level_after;
  logic [PTR_W-1:0]       peak_q, peak_d;
  logic [CNT_W-1:0]       drop_q, drop_d, frames_q, frames_d;
  logic                   do_push, do_pop, ring_full, over;
  logic [FRAME_W-1:0]     ram_rd_data, frame_sel;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                   out_user_q;

  // fill level of a ring from its two slots
  function automatic logic [PTR_W-1:0] ring_level(input logic [PTR_W-1:0] wr,
                                                  input logic [PTR_W-1:0] rd);
    ring_level = (wr >= rd) ? wr - rd : wr - rd + DEPTH_P;
  endfunction

  // slot after the given one, wrapping at the ring end
  function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
    slot_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign wr_next      = slot_inc(wr_q);
  assign rd_next      = slot_inc(rd_q);
  assign level_now    = ring_level(wr_q, rd_q);
  assign ring_empty_o = (wr_q == rd_q);
  assign ring_full    = (wr_next == rd_q);

  assign do_push = cmd_i.accept && cmd_i.kind == KIND_PUSH;
  assign do_pop  = cmd_i.accept && cmd_i.kind == KIND_POP && !ring_empty_o;
  assign over    = do_push && ring_full;

  // pointer and statistics updates
  always_comb begin
    wr_d     = wr_q;
    rd_d     = rd_q;
    peak_d   = peak_q;
    drop_d   = drop_q;
    frames_d = frames_q;
    if (cmd_i.accept) begin
      case (cmd_i.kind)
        KIND_PUSH: begin
          if (level_now > peak_q) begin
            peak_d = level_now;
          end
          if (ring_full) begin
            rd_d   = rd_next;
            drop_d = drop_q + 1'b1;
          end
          wr_d     = wr_next;
          frames_d = frames_q + 1'b1;
        end
        KIND_POP: begin
          if (!ring_empty_o) begin
            rd_d = rd_next;
          end
        end
        KIND_CLEAR: begin
          rd_d = wr_q;
        end
        default: begin
          peak_d   = '0;
          drop_d   = '0;
          frames_d = '0;
        end
      endcase
    end
  end

  assign level_after = ring_level(wr_d, rd_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q     <= '0;
      rd_q     <= '0;
      peak_q   <= '0;
      drop_q   <= '0;
      frames_q <= '0;
    end else begin
      wr_q     <= wr_d;
      rd_q     <= rd_d;
      peak_q   <= peak_d;
      drop_q   <= drop_d;
      frames_q <= frames_d;
    end
  end

  // frame memory, written on push at the write slot, read on pop
  owff_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk_i     (clk_i),
    .wr_en_i   (do_push),
    .wr_addr_i (wr_q),
    .wr_data_i (in_data_i[FRAME_W-1:0]),
    .rd_en_i   (do_pop),
    .rd_addr_i (rd_q),
    .rd_data_o (ram_rd_data)
  );

  // result assembly
  assign frame_sel  = cmd_i.use_ram ? ram_rd_data : '0;
  assign out_data_d = {
    {(OUT_TDATA_W - FRAME_W - OUT_STAT_W){1'b0}},
    over,
    FILL_W'(peak_d),
    frames_d,
    drop_d,
    FILL_W'(level_after),
    frame_sel
  };

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= out_data_d;
      out_user_q <= cmd_i.use_ram;
    end
  end

  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

endmodule

### rtl/core/overwrite_oldest_frame_fifo_unit.sv
// ---------------------------------------------------------------------------
// overwrite_oldest_frame_fifo_unit
// receive fifo for timestamped can frames that overwrites the oldest frame
// ---------------------------------------------------------------------------
// Each request is a push, pop, clear or statistics reset, selected by
// s_axis_tuser, and gives exactly one result. The ring has DEPTH slots and
// holds up to DEPTH-1 frames in a single memory of DEPTH words; a push onto
// a full ring drops the oldest frame. Push, clear, statistics reset and a
// pop of an empty ring load the result directly; a pop that returns a
// frame waits in ST_POP_WAIT for the registered memory read. A new request
// is taken in the same cycle that the waiting result leaves the output
// register, so a stalled result holds off the input. The frame memory needs
// no clearing after reset: a pop only reads slots that a push has written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module overwrite_oldest_frame_fifo_unit import owff_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // in_identifier, in_extended, in_remote, in_length, in_payload,
  // in_timestamp, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [KIND_W-1:0]      s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_identifier, out_extended, out_remote, out_length, out_payload,
  // out_timestamp, fill_level, dropped_total, frames_total, peak_fill,
  // overwrote
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // out_valid
  output logic [0:0]             m_axis_tuser
);

  cmd_t               cmd;
  logic               ring_empty;
  logic               pop_found;
  logic [FRAME_W-1:0] res_frame;
  logic [FILL_W-1:0]  res_fill;
  logic               res_over;

  // controller
  owff_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .ring_empty_i (ring_empty),
    .cmd_o        (cmd)
  );

  // datapath
  owff_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_data_i    (s_axis_tdata),
    .ring_empty_o (ring_empty),
    .out_data_o   (m_axis_tdata),
    .out_user_o   (m_axis_tuser[0])
  );

  // fields watched by the checks
  assign pop_found = s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_POP && !ring_empty;
  assign res_frame = m_axis_tdata[FRAME_W-1:0];
  assign res_fill  = m_axis_tdata[FILL_LSB +: FILL_W];
  assign res_over  = m_axis_tdata[OVER_BIT];

  // a pop that finds a frame holds off the next request for the memory read
  `ASSERT_NEXT(a_pop_wait, clk_i, rst_ni, pop_found, !s_axis_tready)

  // results without a popped frame carry zero frame fields
  `ASSERT_IMPLY(a_zero_frame, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], res_frame == '0)

  // an overwrite leaves the ring full
  `ASSERT_IMPLY(a_over_full, clk_i, rst_ni, m_axis_tvalid && res_over, res_fill == FILL_W'(DEPTH - 1))

endmodule
